// ===== src/fdsa_pkg.sv =====
// ============================================================================
// fdsa_pkg
// Shared constants, types and saturation helpers of the face diffusion stamp
// accumulator.
// ============================================================================
package fdsa_pkg;

    localparam int CELL_W         = 10;
    localparam int CELL_SPAN      = 2 ** CELL_W;
    localparam int CELL_COUNT_DEF = 1024;
    localparam int DATA_W         = 32;
    localparam int ACC_W          = 48;
    localparam int WIDE_W         = 65;

    localparam logic [1:0] OP_INTERIOR = 2'd0;
    localparam logic [1:0] OP_BOUNDARY = 2'd1;
    localparam logic [1:0] OP_READOUT  = 2'd2;

    localparam logic [1:0] KIND_FIXED_VALUE = 2'd0;

    // One request to the cell stores: a read address every cycle and an
    // optional write.
    typedef struct packed {
        logic [CELL_W-1:0] rd_cell;
        logic              wr_en;
        logic [CELL_W-1:0] wr_cell;
        logic              wr_diag;
        logic              wr_rhs;
        logic [ACC_W-1:0]  diag;
        logic [ACC_W-1:0]  rhs;
    } t_store_req;

    typedef struct packed {
        logic ld_prod;
        logic ld_pp;
        logic ld_fb;
    } t_flux_ctl;

    function automatic logic [ACC_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic [ACC_W-1:0] res;
        if (v[WIDE_W-1:ACC_W-1] == '0 || v[WIDE_W-1:ACC_W-1] == '1) begin
            res = v[ACC_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic [ACC_W-1:0] add_sat48(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
        logic signed [WIDE_W-1:0] sum;
        sum = WIDE_W'($signed(a)) + WIDE_W'($signed(b));
        return sat48(sum);
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
        logic [DATA_W-1:0] res;
        if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
            res = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== src/fdsa_store.sv =====
// ============================================================================
// fdsa_store
// Per-cell diagonal and right-hand-side sums in two synchronous memories
// with one write port and one registered read port.
// ============================================================================
module fdsa_store
    import fdsa_pkg::*;
#(
    parameter int CELL_COUNT = CELL_COUNT_DEF
) (
    input  logic             i_clk,
    input  t_store_req       i_req,
    output logic [ACC_W-1:0] o_rd_diag,
    output logic [ACC_W-1:0] o_rd_rhs
);

    localparam int MEM_DEPTH = (CELL_COUNT < CELL_SPAN) ? CELL_COUNT : CELL_SPAN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic [ACC_W-1:0] r_diag_mem [MEM_DEPTH];
    logic [ACC_W-1:0] r_rhs_mem  [MEM_DEPTH];
    logic [ACC_W-1:0] r_rd_diag;
    logic [ACC_W-1:0] r_rd_rhs;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && i_req.wr_diag) begin
            r_diag_mem[i_req.wr_cell[ADDR_W-1:0]] <= i_req.diag;
        end
        if (i_req.wr_en && i_req.wr_rhs) begin
            r_rhs_mem[i_req.wr_cell[ADDR_W-1:0]] <= i_req.rhs;
        end
        r_rd_diag <= r_diag_mem[i_req.rd_cell[ADDR_W-1:0]];
        r_rd_rhs  <= r_rhs_mem[i_req.rd_cell[ADDR_W-1:0]];
    end

    assign o_rd_diag = r_rd_diag;
    assign o_rd_rhs  = r_rd_rhs;

endmodule

// ===== src/fdsa_flux.sv =====
// ============================================================================
// fdsa_flux
// Flux and boundary source arithmetic: coefficient times geometric factor,
// then flux times boundary value as two partial products, all Q16.16 with
// floor rounding, the boundary source with 48-bit saturation.
// ============================================================================
module fdsa_flux
    import fdsa_pkg::*;
(
    input  logic                     i_clk,
    input  t_flux_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0] i_gfac,
    input  logic signed [DATA_W-1:0] i_bval,
    output logic [ACC_W-1:0]         o_flux,
    output logic [ACC_W-1:0]         o_fb
);

    logic signed [2*DATA_W-1:0]      r_prod;
    logic signed [2*DATA_W-1:0]      r_pa;
    logic signed [ACC_W:0]           r_pb;
    logic [ACC_W-1:0]                r_fb;
    logic signed [16:0]              w_lo;
    logic signed [WIDE_W-1:0]        w_sum;

    // The flux is the product shifted right by 16; its upper 32 bits and
    // lower 16 bits are multiplied by the boundary value separately.
    assign w_lo  = $signed({1'b0, r_prod[31:16]});
    assign w_sum = WIDE_W'(r_pa) + WIDE_W'(r_pb >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_prod <= i_coef * i_gfac;
        end
        if (i_ctl.ld_pp) begin
            r_pa <= $signed(r_prod[2*DATA_W-1:DATA_W]) * i_bval;
            r_pb <= w_lo * i_bval;
        end
        if (i_ctl.ld_fb) begin
            r_fb <= sat48(w_sum);
        end
    end

    assign o_flux = r_prod[2*DATA_W-1:16];
    assign o_fb   = r_fb;

endmodule

// ===== src/face_diffusion_stamp_accumulator.sv =====
// ============================================================================
// face_diffusion_stamp_accumulator
// Streaming finite-volume diffusion assembly: one mesh face or one cell
// read-out per item, with per-cell diagonal and right-hand-side sums.
// ============================================================================
// After reset the block sweeps both cell stores to zero, one cell per cycle,
// over min(CELL_COUNT, 1024) cells; no item is taken meanwhile. Items are
// then handled one at a time by a read-modify-write sequencer around the
// cell memories: an interior face goes through product, partial products,
// sum, owner update, neighbour read, neighbour update and two results, a
// fixed-value boundary face through the same steps up to the owner update,
// a read-out reads, sends and clears its cell, and a zero-gradient, empty or
// unknown item is dropped. A stalled result output adds its wait to the
// items that produce results; last_of_run marks each item's final result.
module face_diffusion_stamp_accumulator
    import fdsa_pkg::*;
#(
    parameter int CELL_COUNT = CELL_COUNT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_operation,
    input  logic [CELL_W-1:0]        i_owner_cell,
    input  logic [CELL_W-1:0]        i_neighbour_cell,
    input  logic signed [DATA_W-1:0] i_face_coefficient,
    input  logic signed [DATA_W-1:0] i_geometric_factor,
    input  logic [1:0]               i_boundary_kind,
    input  logic signed [DATA_W-1:0] i_boundary_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [CELL_W-1:0]        o_row_index,
    output logic [CELL_W-1:0]        o_column_index,
    output logic signed [DATA_W-1:0] o_matrix_value,
    output logic signed [DATA_W-1:0] o_rhs_value,
    output logic                     o_last_of_run
);

    localparam int MEM_DEPTH = (CELL_COUNT < CELL_SPAN) ? CELL_COUNT : CELL_SPAN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_PP,
        S_SUM,
        S_UPD_OWN,
        S_RD_NBR,
        S_UPD_NBR,
        S_EMIT0,
        S_EMIT1,
        S_RD_OUT,
        S_OUT_RD
    } t_state;

    t_state                   r_state;
    logic [ADDR_W-1:0]        r_clr;
    logic [1:0]               r_op;
    logic [CELL_W-1:0]        r_own;
    logic [CELL_W-1:0]        r_nbr;
    logic signed [DATA_W-1:0] r_coef;
    logic signed [DATA_W-1:0] r_gfac;
    logic signed [DATA_W-1:0] r_bval;

    logic                     r_out_valid;
    logic [CELL_W-1:0]        r_row;
    logic [CELL_W-1:0]        r_col;
    logic [DATA_W-1:0]        r_mval;
    logic [DATA_W-1:0]        r_rval;
    logic                     r_last;

    t_store_req               s_req;
    t_flux_ctl                s_flux_ctl;
    logic [ACC_W-1:0]         w_rd_diag;
    logic [ACC_W-1:0]         w_rd_rhs;
    logic [ACC_W-1:0]         w_flux;
    logic [ACC_W-1:0]         w_fb;
    logic [DATA_W-1:0]        w_off;
    logic                     w_own_ok;
    logic                     w_nbr_ok;
    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_emit;

    assign w_own_ok   = (32'(r_own) < CELL_COUNT);
    assign w_nbr_ok   = (32'(r_nbr) < CELL_COUNT);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_emit     = w_out_free && (r_state == S_EMIT0 || r_state == S_EMIT1 ||
                                       r_state == S_OUT_RD);
    // The flux never reaches minus 2^47, so its negation fits in 48 bits.
    assign w_off      = sat32(ACC_W'(-$signed(w_flux)));

    assign s_flux_ctl.ld_prod = (r_state == S_MUL);
    assign s_flux_ctl.ld_pp   = (r_state == S_PP);
    assign s_flux_ctl.ld_fb   = (r_state == S_SUM);

    always_comb begin
        s_req         = '0;
        s_req.rd_cell = (r_state == S_RD_NBR) ? r_nbr : r_own;
        case (r_state)
            S_CLEAR: begin
                s_req.wr_en   = 1'b1;
                s_req.wr_cell = CELL_W'(r_clr);
                s_req.wr_diag = 1'b1;
                s_req.wr_rhs  = 1'b1;
            end
            S_UPD_OWN: begin
                s_req.wr_en   = w_own_ok;
                s_req.wr_cell = r_own;
                s_req.wr_diag = 1'b1;
                s_req.wr_rhs  = (r_op == OP_BOUNDARY);
                s_req.diag    = add_sat48(w_rd_diag, w_flux);
                s_req.rhs     = add_sat48(w_rd_rhs, w_fb);
            end
            S_UPD_NBR: begin
                s_req.wr_en   = w_nbr_ok;
                s_req.wr_cell = r_nbr;
                s_req.wr_diag = 1'b1;
                s_req.diag    = add_sat48(w_rd_diag, w_flux);
            end
            S_OUT_RD: begin
                s_req.wr_en   = w_own_ok && w_out_free;
                s_req.wr_cell = r_own;
                s_req.wr_diag = 1'b1;
                s_req.wr_rhs  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= i_operation;
                        r_own  <= i_owner_cell;
                        r_nbr  <= i_neighbour_cell;
                        r_coef <= i_face_coefficient;
                        r_gfac <= i_geometric_factor;
                        r_bval <= i_boundary_value;
                        case (i_operation)
                            OP_INTERIOR: r_state <= S_MUL;
                            OP_BOUNDARY: begin
                                if (i_boundary_kind == KIND_FIXED_VALUE) begin
                                    r_state <= S_MUL;
                                end
                            end
                            OP_READOUT:  r_state <= S_RD_OUT;
                            default:     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL:     r_state <= S_PP;
                S_PP:      r_state <= S_SUM;
                S_SUM:     r_state <= S_UPD_OWN;
                S_UPD_OWN: begin
                    r_state <= (r_op == OP_INTERIOR) ? S_RD_NBR : S_IDLE;
                end
                S_RD_NBR:  r_state <= S_UPD_NBR;
                S_UPD_NBR: r_state <= S_EMIT0;
                S_EMIT0: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_row       <= r_own;
                        r_col       <= r_nbr;
                        r_mval      <= w_off;
                        r_rval      <= '0;
                        r_last      <= 1'b0;
                        r_state     <= S_EMIT1;
                    end
                end
                S_EMIT1: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_row       <= r_nbr;
                        r_col       <= r_own;
                        r_mval      <= w_off;
                        r_rval      <= '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_RD_OUT:  r_state <= S_OUT_RD;
                S_OUT_RD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_row       <= r_own;
                        r_col       <= r_own;
                        r_mval      <= w_own_ok ? sat32(w_rd_diag) : '0;
                        r_rval      <= w_own_ok ? sat32(w_rd_rhs) : '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    fdsa_flux u_flux (
        .i_clk  (i_clk),
        .i_ctl  (s_flux_ctl),
        .i_coef (r_coef),
        .i_gfac (r_gfac),
        .i_bval (r_bval),
        .o_flux (w_flux),
        .o_fb   (w_fb)
    );

    fdsa_store #(
        .CELL_COUNT (CELL_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (s_req),
        .o_rd_diag (w_rd_diag),
        .o_rd_rhs  (w_rd_rhs)
    );

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_row_index    = r_row;
    assign o_column_index = r_col;
    assign o_matrix_value = $signed(r_mval);
    assign o_rhs_value    = $signed(r_rval);
    assign o_last_of_run  = r_last;

    // No result may appear while the stores are being swept.
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result pending during store clearing");

    // The owner update leads to the neighbour update or back to idle only.
    a_upd_own_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD_OWN) |=> (r_state == S_IDLE || r_state == S_RD_NBR))
        else $error("unexpected sequence after owner update");

    // A first-of-pair result waiting means its partner is still to be sent.
    a_pair_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == S_EMIT1))
        else $error("first interior result without its partner pending");

    // A new result comes only from an emitting state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT0 ||
                                $past(r_state) == S_EMIT1 ||
                                $past(r_state) == S_OUT_RD))
        else $error("result raised outside an emitting state");

endmodule
